FILE: design/stq_pkg.sv
package stq_pkg;

  localparam int DefTableDepth = 32;
  localparam int MaxFired      = 32;
  localparam int TagW          = 16;
  localparam int DeltaW        = 31;
  localparam int TimeW         = 48;
  localparam int ExpW          = 49;
  localparam int EntryW        = TagW + ExpW;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_DEL = 2'd1,
    OP_RUN = 2'd2,
    OP_NOP = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    RK_FIRED = 2'd0,
    RK_ADD   = 2'd1,
    RK_DEL   = 2'd2,
    RK_SUM   = 2'd3
  } result_kind_t;

endpackage

FILE: design/stq_ram.sv
module stq_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/sorted_timer_queue_unit.sv
// Sorted timer queue: pending timers live in one RAM, kept in expiry order.
// Add and delete walk the table one entry at a time (read, then shift
// write). Run reads the head and removes each fired timer; each removal
// shifts the remaining entries down; one item is in work at a time.
// Synchronous active-low reset empties the table and clears the latched time;
// the RAM contents are not cleared.
module sorted_timer_queue_unit
  import stq_pkg::*;
#(
  parameter int TABLE_DEPTH = DefTableDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_opcode,
  input  logic [TagW-1:0]     in_timer_tag,
  input  logic [DeltaW-1:0]   in_delay_ms,
  input  logic [TimeW-1:0]    in_now_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_result_kind,
  output logic [TagW-1:0]     out_fired_tag,
  output logic                out_success,
  output logic [DeltaW-1:0]   out_next_delta_ms,
  output logic                out_last
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int FW = $clog2(MaxFired + 1);
  localparam logic [CW-1:0] Full = CW'(TABLE_DEPTH);
  localparam logic [FW-1:0] FireLim = FW'(MaxFired);
  localparam logic [ExpW-1:0] DeltaMax = ExpW'({DeltaW{1'b1}});

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_ARD   = 8'b00000010,  // add: read entry idx-1, wait
    S_ACHK  = 8'b00000100,  // add: compare / shift up
    S_DRD   = 8'b00001000,  // delete: search
    S_DCHK  = 8'b00010000,
    S_RRD   = 8'b00100000,  // run: read head
    S_RCHK  = 8'b01000000,
    S_SHIFT = 8'b10000000   // remove: shift down from idx
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [TimeW-1:0]  ltime_r, ltime_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [FW-1:0]     nfired_r, nfired_nxt;
  logic              sh_rd_r, sh_rd_nxt;   // shift: read issued, data next
  logic              from_run_r, from_run_nxt;
  logic [TagW-1:0]   tag_r, tag_nxt;
  logic [ExpW-1:0]   exp_r, exp_nxt;

  logic              ov_r, ov_nxt;
  logic [1:0]        okind_r, okind_nxt;
  logic [TagW-1:0]   otag_r, otag_nxt;
  logic              osucc_r, osucc_nxt;
  logic [DeltaW-1:0] odelta_r, odelta_nxt;
  logic              olast_r, olast_nxt;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [EntryW-1:0] wdata, rdata;
  logic [TagW-1:0]   rd_tag;
  logic [ExpW-1:0]   rd_exp, diff;

  assign rd_tag = rdata[EntryW-1 -: TagW];
  assign rd_exp = rdata[ExpW-1:0];
  assign diff   = rd_exp - {1'b0, ltime_r};

  stq_ram #(.Width(EntryW), .Depth(TABLE_DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign in_ready          = (state_r == S_IDLE) && !ov_r;
  assign out_valid         = ov_r;
  assign out_result_kind   = okind_r;
  assign out_fired_tag     = otag_r;
  assign out_success       = osucc_r;
  assign out_next_delta_ms = odelta_r;
  assign out_last          = olast_r;

  // Sequencer: every result waits in the output register until taken.
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ltime_nxt    = ltime_r;
    idx_nxt      = idx_r;
    nfired_nxt   = nfired_r;
    sh_rd_nxt    = sh_rd_r;
    from_run_nxt = from_run_r;
    tag_nxt      = tag_r;
    exp_nxt      = exp_r;
    ov_nxt       = ov_r && !out_ready;
    okind_nxt    = okind_r;
    otag_nxt     = otag_r;
    osucc_nxt    = osucc_r;
    odelta_nxt   = odelta_r;
    olast_nxt    = olast_r;
    we           = 1'b0;
    waddr        = idx_r[AW-1:0];
    wdata        = {tag_r, exp_r};
    raddr        = idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          tag_nxt = in_timer_tag;
          exp_nxt = {1'b0, ltime_r} + ExpW'(in_delay_ms);
          case (opcode_t'(in_opcode))
            OP_ADD: begin
              if (count_r == Full) begin
                ov_nxt = 1'b1; okind_nxt = RK_ADD; otag_nxt = '0;
                osucc_nxt = 1'b0; odelta_nxt = '0; olast_nxt = 1'b1;
              end else begin
                // Walk from the tail, shifting later entries up.
                idx_nxt = count_r;
                state_nxt = S_ARD;
              end
            end
            OP_DEL: begin
              idx_nxt = '0;
              state_nxt = S_DRD;
            end
            OP_RUN: begin
              ltime_nxt = in_now_ms;
              nfired_nxt = '0;
              state_nxt = S_RRD;
            end
            default: ;
          endcase
        end
      end

      S_ARD: begin
        if (idx_r == '0) begin
          we = 1'b1; waddr = '0;
          count_nxt = count_r + 1'b1;
          ov_nxt = 1'b1; okind_nxt = RK_ADD; otag_nxt = '0;
          osucc_nxt = 1'b1; odelta_nxt = '0; olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          raddr = AW'(idx_r - 1'b1);
          state_nxt = S_ACHK;
        end
      end

      S_ACHK: begin
        if (rd_exp > exp_r) begin
          we = 1'b1; wdata = rdata;
          idx_nxt = idx_r - 1'b1;
          state_nxt = S_ARD;
        end else begin
          we = 1'b1;
          count_nxt = count_r + 1'b1;
          ov_nxt = 1'b1; okind_nxt = RK_ADD; otag_nxt = '0;
          osucc_nxt = 1'b1; odelta_nxt = '0; olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_DRD: begin
        if (idx_r >= count_r) begin
          ov_nxt = 1'b1; okind_nxt = RK_DEL; otag_nxt = '0;
          osucc_nxt = 1'b1; odelta_nxt = '0; olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DCHK;
        end
      end

      S_DCHK: begin
        if (rd_tag == tag_r) begin
          from_run_nxt = 1'b0;
          sh_rd_nxt = 1'b0;
          state_nxt = S_SHIFT;
        end else begin
          idx_nxt = idx_r + 1'b1;
          raddr = AW'(idx_r + 1'b1);
          state_nxt = S_DRD;
        end
      end

      S_RRD: begin
        raddr = '0;
        if (!ov_r || out_ready) begin
          if (count_r == '0) begin
            ov_nxt = 1'b1; okind_nxt = RK_SUM; otag_nxt = '0;
            osucc_nxt = 1'b1; odelta_nxt = '0; olast_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RCHK;
          end
        end
      end

      S_RCHK: begin
        if (rd_exp <= {1'b0, ltime_r} && nfired_r != FireLim) begin
          ov_nxt = 1'b1; okind_nxt = RK_FIRED; otag_nxt = rd_tag;
          osucc_nxt = 1'b1; odelta_nxt = '0; olast_nxt = 1'b0;
          nfired_nxt = nfired_r + 1'b1;
          idx_nxt = '0;
          from_run_nxt = 1'b1;
          sh_rd_nxt = 1'b0;
          state_nxt = S_SHIFT;
        end else begin
          ov_nxt = 1'b1; okind_nxt = RK_SUM; otag_nxt = '0;
          osucc_nxt = 1'b1; olast_nxt = 1'b1;
          if (rd_exp <= {1'b0, ltime_r}) odelta_nxt = '0;
          else if (diff > DeltaMax) odelta_nxt = DeltaMax[DeltaW-1:0];
          else odelta_nxt = diff[DeltaW-1:0];
          state_nxt = S_IDLE;
        end
      end

      S_SHIFT: begin
        // Move entry idx+1 down into idx until the tail is reached.
        if (idx_r + 1'b1 >= count_r) begin
          count_nxt = count_r - 1'b1;
          idx_nxt = '0;
          state_nxt = from_run_r ? S_RRD : S_IDLE;
          if (!from_run_r) begin
            ov_nxt = 1'b1; okind_nxt = RK_DEL; otag_nxt = '0;
            osucc_nxt = 1'b1; odelta_nxt = '0; olast_nxt = 1'b1;
          end
        end else if (!sh_rd_r) begin
          raddr = AW'(idx_r + 1'b1);
          sh_rd_nxt = 1'b1;
        end else begin
          we = 1'b1; wdata = rdata;
          idx_nxt = idx_r + 1'b1;
          sh_rd_nxt = 1'b0;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state is cleared by reset; payload registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ltime_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ltime_r <= ltime_nxt;
      ov_r    <= ov_nxt;
    end
    idx_r      <= idx_nxt;
    nfired_r   <= nfired_nxt;
    sh_rd_r    <= sh_rd_nxt;
    from_run_r <= from_run_nxt;
    tag_r      <= tag_nxt;
    exp_r      <= exp_nxt;
    okind_r    <= okind_nxt;
    otag_r     <= otag_nxt;
    osucc_r    <= osucc_nxt;
    odelta_r   <= odelta_nxt;
    olast_r    <= olast_nxt;
  end

endmodule

FILE: design/stq_checker.sv
module stq_checker
  import stq_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_result_kind,
  input logic [TagW-1:0]   out_fired_tag,
  input logic              out_success,
  input logic [DeltaW-1:0] out_next_delta_ms,
  input logic              out_last
);

  // A word held under stall keeps its kind and tag.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind)
      && $stable(out_fired_tag))
    else $error("result word changed while stalled");

  // Fired words are never the last of a run.
  a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RK_FIRED |-> !out_last)
    else $error("fired word marked last");

  // Only add status may report failure.
  a_success: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_success |-> out_result_kind == RK_ADD)
    else $error("failure on non-add word");

  // Delta appears only on a summary.
  a_delta: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != RK_SUM |-> out_next_delta_ms == '0)
    else $error("delta outside summary");

  // No input is taken while a result is pending.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(in_valid && in_ready))
    else $error("input accepted with result pending");

endmodule

bind sorted_timer_queue_unit stq_checker u_stq_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import stq_pkg::*;

  localparam int Depth = DefTableDepth;

  // One pending timer as the checker sees it.
  typedef struct {
    logic [TagW-1:0] tag;
    logic [ExpW-1:0] expiry;
  } timer_t;

  // One expected result word.
  typedef struct packed {
    logic [1:0]        kind;
    logic [TagW-1:0]   tag;
    logic              success;
    logic [DeltaW-1:0] delta;
    logic              last;
  } timer_word_t;

  // One row of the directed table; has_word marks a typed-in expectation.
  typedef struct {
    opcode_t           op;
    logic [TagW-1:0]   tag;
    logic [DeltaW-1:0] delay;
    logic [TimeW-1:0]  now;
    bit                has_word;
    timer_word_t       word;
  } timer_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_opcode;
  logic [TagW-1:0]   in_timer_tag;
  logic [DeltaW-1:0] in_delay_ms;
  logic [TimeW-1:0]  in_now_ms;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_result_kind;
  logic [TagW-1:0]   out_fired_tag;
  logic              out_success;
  logic [DeltaW-1:0] out_next_delta_ms;
  logic              out_last;

  timer_t      pending_timers[$];
  logic [TimeW-1:0] model_time;
  timer_word_t expected_words[$];
  int          fail_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_off;
  logic [TimeW-1:0] clock_ms;

  sorted_timer_queue_unit #(.TABLE_DEPTH(Depth)) i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fail-safe limit on the whole run.
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic timer_word_t make_word(logic [1:0] kind, logic [TagW-1:0] tag,
                                            logic ok, logic [DeltaW-1:0] delta,
                                            logic last);
    timer_word_t w;
    w.kind = kind;
    w.tag = tag;
    w.success = ok;
    w.delta = delta;
    w.last = last;
    return w;
  endfunction

  // Apply one accepted item to the mirrored table and queue its results.
  task automatic predict_timer_op(opcode_t op, logic [TagW-1:0] tag,
                                  logic [DeltaW-1:0] delay, logic [TimeW-1:0] now);
    timer_t t;
    int pos;
    int fired;
    logic [ExpW-1:0] gap;
    logic [DeltaW-1:0] delta;
    case (op)
      OP_ADD: begin
        if (pending_timers.size() >= Depth) begin
          expected_words.push_back(make_word(RK_ADD, '0, 1'b0, '0, 1'b1));
        end else begin
          t.tag = tag;
          t.expiry = {1'b0, model_time} + {18'd0, delay};
          pos = pending_timers.size();
          for (int i = 0; i < pending_timers.size(); i++) begin
            if (pending_timers[i].expiry > t.expiry) begin
              pos = i;
              break;
            end
          end
          pending_timers.insert(pos, t);
          expected_words.push_back(make_word(RK_ADD, '0, 1'b1, '0, 1'b1));
        end
      end
      OP_DEL: begin
        for (int i = 0; i < pending_timers.size(); i++) begin
          if (pending_timers[i].tag == tag) begin
            pending_timers.delete(i);
            break;
          end
        end
        expected_words.push_back(make_word(RK_DEL, '0, 1'b1, '0, 1'b1));
      end
      OP_RUN: begin
        model_time = now;
        fired = 0;
        while (pending_timers.size() > 0 && fired < MaxFired &&
               pending_timers[0].expiry <= {1'b0, model_time}) begin
          expected_words.push_back(make_word(RK_FIRED, pending_timers[0].tag, 1'b1,
                                             '0, 1'b0));
          void'(pending_timers.pop_front());
          fired++;
        end
        delta = '0;
        if (pending_timers.size() > 0 && pending_timers[0].expiry > {1'b0, model_time}) begin
          gap = pending_timers[0].expiry - {1'b0, model_time};
          delta = (gap > {18'd0, {DeltaW{1'b1}}}) ? {DeltaW{1'b1}} : gap[DeltaW-1:0];
        end
        expected_words.push_back(make_word(RK_SUM, '0, 1'b1, delta, 1'b1));
      end
      default: ;
    endcase
  endtask

  // Offer one word and hold it until it is taken.
  task automatic send_timer_op(opcode_t op, logic [TagW-1:0] tag,
                               logic [DeltaW-1:0] delay, logic [TimeW-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_timer_tag <= tag;
    in_delay_ms <= delay;
    in_now_ms <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_timer_op(op, tag, delay, now);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted word with the oldest expectation.
  always @(posedge clk) begin
    timer_word_t exp_w;
    timer_word_t got_w;
    if (rst_n && out_valid && out_ready) begin
      got_w = make_word(out_result_kind, out_fired_tag, out_success, out_next_delta_ms,
                        out_last);
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got_w);
        fail_count++;
      end else begin
        exp_w = expected_words.pop_front();
        if (got_w.kind !== exp_w.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, exp_w.kind, got_w.kind);
          fail_count++;
        end
        if (got_w.tag !== exp_w.tag) begin
          $display("%0t: tag expected %h actual %h", $time, exp_w.tag, got_w.tag);
          fail_count++;
        end
        if (got_w.success !== exp_w.success) begin
          $display("%0t: success expected %b actual %b", $time, exp_w.success,
                   got_w.success);
          fail_count++;
        end
        if (got_w.delta !== exp_w.delta) begin
          $display("%0t: delta expected %0d actual %0d", $time, exp_w.delta, got_w.delta);
          fail_count++;
        end
        if (got_w.last !== exp_w.last) begin
          $display("%0t: last expected %b actual %b", $time, exp_w.last, got_w.last);
          fail_count++;
        end
      end
    end
  end

  // Directed rows, a fill-and-fire sequence, then random timer traffic in several idling phases.
  initial begin
    timer_row_t rows[$];
    timer_row_t r;
    timer_word_t w;
    int phase;
    int pick;
    logic [TagW-1:0] tag_v;
    logic [DeltaW-1:0] delay_v;
    logic [TagW-1:0] used_tags[$];
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    model_time = '0;
    clock_ms = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_NOP;
    in_timer_tag = '0;
    in_delay_ms = '0;
    in_now_ms = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty run after reset, delete miss, extremes of delay and time.
    rows.push_back('{OP_RUN, 16'h0, 31'h0, 48'h0, 1'b1,
                     make_word(RK_SUM, '0, 1'b1, '0, 1'b1)});
    rows.push_back('{OP_DEL, 16'hFFFF, 31'h0, 48'h0, 1'b1,
                     make_word(RK_DEL, '0, 1'b1, '0, 1'b1)});
    rows.push_back('{OP_ADD, 16'hFFFF, 31'h7FFFFFFF, 48'h0, 1'b1,
                     make_word(RK_ADD, '0, 1'b1, '0, 1'b1)});
    rows.push_back('{OP_RUN, 16'h0, 31'h0, 48'h0, 1'b1,
                     make_word(RK_SUM, '0, 1'b1, 31'h7FFFFFFF, 1'b1)});
    rows.push_back('{OP_ADD, 16'h0000, 31'h0, 48'h0, 1'b0, '0});
    rows.push_back('{OP_ADD, 16'h0001, 31'h0, 48'h0, 1'b0, '0});
    rows.push_back('{OP_ADD, 16'h0002, 31'h5, 48'h0, 1'b0, '0});
    rows.push_back('{OP_NOP, 16'h1234, 31'h9, 48'h9, 1'b0, '0});
    rows.push_back('{OP_DEL, 16'h0001, 31'h0, 48'h0, 1'b0, '0});
    rows.push_back('{OP_RUN, 16'h0, 31'h0, 48'h3, 1'b0, '0});
    rows.push_back('{OP_RUN, 16'h0, 31'h0, 48'hFFFFFFFFFFFF, 1'b0, '0});
    // A delay at its top past the maximum time, then time going backward.
    rows.push_back('{OP_ADD, 16'hA5A5, 31'h7FFFFFFF, 48'h0, 1'b0, '0});
    rows.push_back('{OP_RUN, 16'h0, 31'h0, 48'h10, 1'b0, '0});
    rows.push_back('{OP_RUN, 16'h0, 31'h0, 48'h80000010, 1'b0, '0});
    foreach (rows[i]) begin
      r = rows[i];
      send_timer_op(r.op, r.tag, r.delay, r.now);
      if (r.has_word) begin
        w = expected_words[$];
        if (w !== r.word) begin
          $display("%0t: row %0d expected %h actual prediction %h", $time, i, r.word, w);
          fail_count++;
        end
      end
    end
    go_idle();
    clock_ms = model_time;

    // Empty the table, fill it, add on full, then a run that fires the cap of timers.
    send_timer_op(OP_DEL, 16'hA5A5, '0, '0);
    for (int i = 0; i <= Depth; i++)
      send_timer_op(OP_ADD, 16'(i + 16'h100), 31'(i % 3), '0);
    send_timer_op(OP_ADD, 16'h5A5A, 31'h1, '0);
    send_timer_op(OP_RUN, '0, '0, clock_ms + 48'd10);
    send_timer_op(OP_RUN, '0, '0, clock_ms + 48'd10);
    clock_ms = clock_ms + 48'd10;
    go_idle();

    // Random phases; the first phase carries the long receiver hold-off.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 46; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 46; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      if (phase == 0) hold_off = 1'b1;
      for (int n = 0; n < 43; n++) begin
        pick = $urandom_range(99);
        tag_v = (used_tags.size() > 0 && $urandom_range(1)) ?
                used_tags[$urandom_range(used_tags.size() - 1)] : 16'($urandom);
        delay_v = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(60));
        if (pick < 50) begin
          used_tags.push_back(tag_v);
          send_timer_op(OP_ADD, tag_v, delay_v, 48'($urandom) << 16);
        end else if (pick < 70) begin
          send_timer_op(OP_DEL, tag_v, delay_v, 48'($urandom));
        end else if (pick < 97) begin
          if ($urandom_range(19) == 0)
            clock_ms = {$urandom, 16'($urandom)};
          else
            clock_ms = clock_ms + 48'($urandom_range(40));
          send_timer_op(OP_RUN, 16'($urandom), 31'($urandom), clock_ms);
        end else begin
          send_timer_op(OP_NOP, 16'($urandom), 31'($urandom), 48'($urandom));
        end
      end
      go_idle();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
